[hdl/skt_pkg.sv]
// Shared types, widths and codes for the sorted key table.
package skt_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 7;
  localparam int KEY_W = 16;
  localparam int VAL_W = 32;
  localparam int ACT_W = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [ACT_W-1:0] act_t;

  localparam act_t ACT_INSERT  = 3'd0;
  localparam act_t ACT_DEL_KEY = 3'd1;
  localparam act_t ACT_SEARCH  = 3'd2;
  localparam act_t ACT_DEL_POS = 3'd3;
  localparam act_t ACT_CLEAR   = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DEL_KEY,
    CELL_DEL_POS
  } cell_mode_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_mode_t mode;
    cnt_t       position;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

[hdl/sorted_key_table.sv]
// Top level of the sorted key table: request control, cell chain and result register.
//
// Usage: drive in_action, in_key, in_value and in_position and raise start;
// the item is taken at a rising edge where start is high and busy is low.
// Each item gives one result, shown for exactly one cycle with out_valid
// high: out_ok, out_found_position, out_found_value and out_count.
// Timing: the accepting edge enters the execute state; the edge that ends it
// loads the result register and raises out_valid. Busy is high for one cycle,
// in the execute state, so the block takes no new item until the last is
// executed: a compare step in which every cell registers its less-than and
// equal flags, then an execute step in which the flags are encoded and every
// cell shifts left, right or holds in the same edge.
// The receiver cannot stall; results must be taken when out_valid is high.
// Reset (rst_n low at a clock edge) empties the table, drops any item in
// flight and clears out_valid. Slot contents are not cleared; slots beyond
// the count are never reported.
module sorted_key_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  skt_pkg::act_t in_action,
  input  skt_pkg::key_t in_key,
  input  skt_pkg::val_t in_value,
  input  skt_pkg::cnt_t in_position,
  output logic          out_valid,
  output logic          out_ok,
  output skt_pkg::cnt_t out_found_position,
  output skt_pkg::val_t out_found_value,
  output skt_pkg::cnt_t out_count
);
  import skt_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  // Request held for the execute cycle.
  act_t req_action_r;
  key_t req_key_r;
  val_t req_value_r;
  cnt_t req_position_r;

  cnt_t count_r, count_nxt;

  // Result register.
  logic out_valid_r;
  logic out_ok_r, ok_nxt;
  cnt_t out_pos_r, pos_nxt;
  val_t out_value_r, value_nxt;
  cnt_t out_count_r;

  // Cell chain wiring.
  key_t             cell_key   [DEPTH];
  val_t             cell_value [DEPTH];
  key_t             left_key   [DEPTH];
  val_t             left_value [DEPTH];
  key_t             right_key  [DEPTH];
  val_t             right_value[DEPTH];
  logic [DEPTH-1:0] lt_vec;
  logic [DEPTH-1:0] eq_vec;
  logic [DEPTH-1:0] prev_lt;
  cell_cmd_t        cmd;

  idx_t first_idx;
  logic any_eq;
  val_t eq_value;
  logic full;
  logic pos_ok;
  cnt_t hit_pos;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start && !busy;

  // Hook each cell to its neighbors; the chain ends feed zero keys and values.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_key[i]   = '0;
      assign left_value[i] = '0;
      assign prev_lt[i]    = 1'b1;
    end else begin : g_mid_l
      assign left_key[i]   = cell_key[i-1];
      assign left_value[i] = cell_value[i-1];
      assign prev_lt[i]    = lt_vec[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_key[i]   = '0;
      assign right_value[i] = '0;
    end else begin : g_mid_r
      assign right_key[i]   = cell_key[i+1];
      assign right_value[i] = cell_value[i+1];
    end

    skt_cell u_cell (
      .clk         (clk),
      .cell_idx    (IDX_W'(i)),
      .count       (count_r),
      .cmp_en      (accept),
      .cmp_key     (in_key),
      .prev_lt     (prev_lt[i]),
      .cmd         (cmd),
      .new_key     (req_key_r),
      .new_value   (req_value_r),
      .left_key    (left_key[i]),
      .left_value  (left_value[i]),
      .right_key   (right_key[i]),
      .right_value (right_value[i]),
      .cell_key    (cell_key[i]),
      .cell_value  (cell_value[i]),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  skt_encode u_encode (
    .lt_vec    (lt_vec),
    .eq_vec    (eq_vec),
    .values    (cell_value),
    .first_idx (first_idx),
    .any_eq    (any_eq),
    .eq_value  (eq_value)
  );

  assign full    = (count_r == CNT_W'(DEPTH));
  assign pos_ok  = (req_position_r != '0) && (req_position_r <= count_r);
  // Slot of a hit, or the ordered slot for a new key (one-based).
  assign hit_pos = CNT_W'(first_idx) + CNT_W'(1);

  // Execute: decide the outcome and steer every cell of the chain at the same edge.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ok_nxt       = 1'b0;
    pos_nxt      = '0;
    value_nxt    = '0;
    cmd.mode     = CELL_HOLD;
    cmd.position = req_position_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (req_action_r)
          ACT_INSERT: begin
            if (!full && !any_eq) begin
              ok_nxt    = 1'b1;
              pos_nxt   = hit_pos;
              count_nxt = count_r + CNT_W'(1);
              cmd.mode  = CELL_INSERT;
            end
          end
          ACT_DEL_KEY: begin
            if (any_eq) begin
              ok_nxt    = 1'b1;
              pos_nxt   = hit_pos;
              count_nxt = count_r - CNT_W'(1);
              cmd.mode  = CELL_DEL_KEY;
            end
          end
          ACT_SEARCH: begin
            if (any_eq) begin
              ok_nxt    = 1'b1;
              pos_nxt   = hit_pos;
              value_nxt = eq_value;
            end
          end
          ACT_DEL_POS: begin
            if (pos_ok) begin
              ok_nxt    = 1'b1;
              pos_nxt   = req_position_r;
              count_nxt = count_r - CNT_W'(1);
              cmd.mode  = CELL_DEL_POS;
            end
          end
          ACT_CLEAR: begin
            ok_nxt    = 1'b1;
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  // Payload: capture the request, then the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action_r   <= in_action;
      req_key_r      <= in_key;
      req_value_r    <= in_value;
      req_position_r <= in_position;
    end
    if (state_r == ST_EXEC) begin
      out_ok_r    <= ok_nxt;
      out_pos_r   <= pos_nxt;
      out_value_r <= value_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_found_position = out_pos_r;
  assign out_found_value    = out_value_r;
  assign out_count          = out_count_r;

endmodule

[hdl/skt_cell.sv]
// One table slot: holds a key and value, compares and shifts with its neighbors.
module skt_cell (
  input  logic              clk,
  input  skt_pkg::idx_t     cell_idx,
  input  skt_pkg::cnt_t     count,
  input  logic              cmp_en,
  input  skt_pkg::key_t     cmp_key,
  input  logic              prev_lt,
  input  skt_pkg::cell_cmd_t cmd,
  input  skt_pkg::key_t     new_key,
  input  skt_pkg::val_t     new_value,
  input  skt_pkg::key_t     left_key,
  input  skt_pkg::val_t     left_value,
  input  skt_pkg::key_t     right_key,
  input  skt_pkg::val_t     right_value,
  output skt_pkg::key_t     cell_key,
  output skt_pkg::val_t     cell_value,
  output logic              lt,
  output logic              eq
);
  import skt_pkg::*;

  key_t key_r, key_nxt;
  val_t value_r, value_nxt;
  logic lt_r, eq_r;
  logic occupied;
  logic at_or_after;

  assign occupied    = CNT_W'(cell_idx) < count;
  assign at_or_after = (CNT_W'(cell_idx) + CNT_W'(1)) >= cmd.position;

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    case (cmd.mode)
      CELL_INSERT: begin
        if (!lt_r) begin
          if (prev_lt) begin
            key_nxt   = new_key;
            value_nxt = new_value;
          end else begin
            key_nxt   = left_key;
            value_nxt = left_value;
          end
        end
      end
      CELL_DEL_KEY: begin
        if (!lt_r) begin
          key_nxt   = right_key;
          value_nxt = right_value;
        end
      end
      CELL_DEL_POS: begin
        if (at_or_after) begin
          key_nxt   = right_key;
          value_nxt = right_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    if (cmp_en) begin
      lt_r <= occupied && (key_r < cmp_key);
      eq_r <= occupied && (key_r == cmp_key);
    end
  end

  assign cell_key   = key_r;
  assign cell_value = value_r;
  assign lt         = lt_r;
  assign eq         = eq_r;

endmodule

[hdl/skt_encode.sv]
// Reduces the cells' compare flags to a slot index, a hit flag and the hit value.
module skt_encode (
  input  logic [skt_pkg::DEPTH-1:0] lt_vec,
  input  logic [skt_pkg::DEPTH-1:0] eq_vec,
  input  skt_pkg::val_t             values [skt_pkg::DEPTH],
  output skt_pkg::idx_t             first_idx,
  output logic                      any_eq,
  output skt_pkg::val_t             eq_value
);
  import skt_pkg::*;

  logic [DEPTH-1:0] first_zero;

  // The less-than flags form a run of ones; mark the slot right after it.
  assign first_zero = ~lt_vec & {lt_vec[DEPTH-2:0], 1'b1};
  assign any_eq     = |eq_vec;

  always_comb begin
    first_idx = '0;
    eq_value  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_zero[i]) first_idx = first_idx | IDX_W'(i);
      if (eq_vec[i])     eq_value  = eq_value | values[i];
    end
  end

endmodule
